@@ hdl/softmax_gradient_hessian_macros.svh @@
// Assertion macros used by the softmax gradient and hessian RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SOFTMAX_GRADIENT_HESSIAN_MACROS_SVH
`define SOFTMAX_GRADIENT_HESSIAN_MACROS_SVH
`ifndef SYNTHESIS
`define SMGH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("smgh assertion failed");
`define SMGH_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
	else $error("smgh forbidden condition seen");
`else
`define SMGH_ASSERT(lbl, clk, rst_n, prop)
`define SMGH_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hdl/smgh_pkg.sv @@
// Package of the softmax gradient and hessian block: payload types, widths, exp tables.
// Used by the top level, the front part and the back part; depends on nothing.
package smgh_pkg;

	localparam int MAX_CLASSES_DEF = 16;
	localparam int LOGIT_W = 16;
	localparam int EXP_W = 16;
	localparam int EXP_INT_STEPS = 12;
	localparam logic [1:0] ADDR_NUM_CLASSES = 2'd0;

	typedef struct packed {
		logic signed [15:0] logit;
		logic [4:0] class_label;
	} item_t;

	typedef struct packed {
		logic [3:0] class_index;
		logic signed [15:0] gradient;
		logic [14:0] hessian;
		logic last_class;
	} result_t;

	function automatic logic [16:0] exp_int(input logic [3:0] ip);
		logic [16:0] v;
		unique case (ip)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd24109;
			4'd2: v = 17'd8869;
			4'd3: v = 17'd3263;
			4'd4: v = 17'd1200;
			4'd5: v = 17'd442;
			4'd6: v = 17'd162;
			4'd7: v = 17'd60;
			4'd8: v = 17'd22;
			4'd9: v = 17'd8;
			4'd10: v = 17'd3;
			4'd11: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] exp_hi(input logic [3:0] h);
		logic [16:0] v;
		unique case (h)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd61565;
			4'd2: v = 17'd57835;
			4'd3: v = 17'd54331;
			4'd4: v = 17'd51039;
			4'd5: v = 17'd47947;
			4'd6: v = 17'd45042;
			4'd7: v = 17'd42313;
			4'd8: v = 17'd39750;
			4'd9: v = 17'd37341;
			4'd10: v = 17'd35079;
			4'd11: v = 17'd32954;
			4'd12: v = 17'd30957;
			4'd13: v = 17'd29081;
			4'd14: v = 17'd27319;
			default: v = 17'd25664;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] exp_lo(input logic [3:0] l);
		logic [16:0] v;
		unique case (l)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd65280;
			4'd2: v = 17'd65026;
			4'd3: v = 17'd64772;
			4'd4: v = 17'd64520;
			4'd5: v = 17'd64268;
			4'd6: v = 17'd64018;
			4'd7: v = 17'd63768;
			4'd8: v = 17'd63520;
			4'd9: v = 17'd63272;
			4'd10: v = 17'd63025;
			4'd11: v = 17'd62780;
			4'd12: v = 17'd62535;
			4'd13: v = 17'd62291;
			4'd14: v = 17'd62048;
			default: v = 17'd61806;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/softmax_gradient_hessian.sv @@
// Top level of the softmax cross-entropy gradient and hessian block.
// Depends on smgh_pkg, smgh_ram, smgh_front and smgh_back.
//
// Channel   Handshake                               Payload
// item      start & !busy                           item_t (logit, class_label)
// result    result_strobe, one cycle, no hold       result_t
// config    APB write, psel&penable&pwrite&pready   num_classes at address 0
//
// The front end accepts a logit whenever start is high and busy is low; the last logit of an
// example queues a job. The back end then takes the job and runs the exp pass, the reciprocal
// and the result pass; busy is high from the last logit until the last result is strobed.
// Reset is asynchronous and leaves num_classes at 2 with no partial example.
// The receiver cannot stall; results are strobed one class at a time, in class order.
module softmax_gradient_hessian #(
	parameter int MAX_CLASSES = smgh_pkg::MAX_CLASSES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  smgh_pkg::item_t    item,
	output logic               result_strobe,
	output smgh_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import smgh_pkg::*;
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int IW = $clog2(MAX_CLASSES);

	logic [4:0] num_classes_q;
	logic [CW-1:0] n_active;
	logic cfg_wr;
	logic accept;
	logic job_valid, job_take, back_active;
	logic signed [15:0] job_max;
	logic [4:0] job_label;
	logic logit_we;
	logic [IW-1:0] logit_waddr, logit_raddr, exp_addr;
	logic [15:0] logit_wdata, logit_rdata, exp_wdata, exp_rdata;
	logic exp_we;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_NUM_CLASSES);
	assign prdata = {27'd0, num_classes_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= 5'd2;
		end else if (cfg_wr) begin
			num_classes_q <= pwdata[4:0];
		end
	end

	always_comb begin
		if (num_classes_q < 5'd2) begin
			n_active = CW'(2);
		end else if (32'(num_classes_q) > MAX_CLASSES) begin
			n_active = CW'(MAX_CLASSES);
		end else begin
			n_active = CW'(num_classes_q);
		end
	end

	assign busy = job_valid || back_active;
	assign accept = start && !busy;

	smgh_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .item(item), .n_active(n_active),
		.cfg_clear(cfg_wr), .job_take(job_take), .job_valid(job_valid),
		.job_max(job_max), .job_label(job_label), .we(logit_we),
		.waddr(logit_waddr), .wdata(logit_wdata)
	);

	smgh_ram #(.WIDTH(LOGIT_W), .DEPTH(MAX_CLASSES)) u_logit_ram (
		.clk(clk), .we(logit_we), .waddr(logit_waddr), .wdata(logit_wdata),
		.raddr(logit_raddr), .rdata(logit_rdata)
	);

	smgh_ram #(.WIDTH(EXP_W), .DEPTH(MAX_CLASSES)) u_exp_ram (
		.clk(clk), .we(exp_we), .waddr(exp_addr), .wdata(exp_wdata),
		.raddr(exp_addr), .rdata(exp_rdata)
	);

	smgh_back #(.MAX_CLASSES(MAX_CLASSES)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_max(job_max),
		.job_label(job_label), .n_active(n_active), .job_take(job_take),
		.active(back_active), .logit_raddr(logit_raddr), .logit_rdata(logit_rdata),
		.exp_we(exp_we), .exp_addr(exp_addr), .exp_wdata(exp_wdata),
		.exp_rdata(exp_rdata), .result_strobe(result_strobe), .result(result)
	);
endmodule

@@ hdl/smgh_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the logit and exp stores; no dependencies.
module smgh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/smgh_front.sv @@
// Front part: accepts logits, writes the logit store, tracks the maximum, queues a job.
// Depends on smgh_pkg.
module smgh_front #(
	parameter int MAX_CLASSES = smgh_pkg::MAX_CLASSES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  smgh_pkg::item_t                    item,
	input  logic [$clog2(MAX_CLASSES+1)-1:0]   n_active,
	input  logic                               cfg_clear,
	input  logic                               job_take,
	output logic                               job_valid,
	output logic signed [15:0]                 job_max,
	output logic [4:0]                         job_label,
	output logic                               we,
	output logic [$clog2(MAX_CLASSES)-1:0]     waddr,
	output logic [15:0]                        wdata
);
	import smgh_pkg::*;
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int IW = $clog2(MAX_CLASSES);

	logic [CW-1:0] fill_q;
	logic signed [15:0] max_q;
	logic signed [15:0] new_max;
	logic job_valid_q;
	logic signed [15:0] job_max_q;
	logic [4:0] job_label_q;
	logic last;

	assign new_max = (item.logit > max_q) ? item.logit : max_q;
	assign last = (fill_q == n_active - CW'(1));
	assign we = accept;
	assign waddr = fill_q[IW-1:0];
	assign wdata = item.logit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			max_q <= 16'sh8000;
			job_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				job_valid_q <= 1'b0;
			end
			if (cfg_clear) begin
				fill_q <= '0;
				max_q <= 16'sh8000;
			end else if (accept) begin
				if (last) begin
					fill_q <= '0;
					max_q <= 16'sh8000;
					job_valid_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CW'(1);
					max_q <= new_max;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			job_max_q <= new_max;
			job_label_q <= item.class_label;
		end
	end

	assign job_valid = job_valid_q;
	assign job_max = job_max_q;
	assign job_label = job_label_q;
endmodule

@@ hdl/smgh_back.sv @@
// Back part: exp pass, reciprocal by restoring division, probability and result pass.
// Depends on smgh_pkg, the macros header and two smgh_ram instances in the top level.
`include "softmax_gradient_hessian_macros.svh"
module smgh_back #(
	parameter int MAX_CLASSES = smgh_pkg::MAX_CLASSES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	input  logic signed [15:0]               job_max,
	input  logic [4:0]                       job_label,
	input  logic [$clog2(MAX_CLASSES+1)-1:0] n_active,
	output logic                             job_take,
	output logic                             active,
	output logic [$clog2(MAX_CLASSES)-1:0]   logit_raddr,
	input  logic [15:0]                      logit_rdata,
	output logic                             exp_we,
	output logic [$clog2(MAX_CLASSES)-1:0]   exp_addr,
	output logic [15:0]                      exp_wdata,
	input  logic [15:0]                      exp_rdata,
	output logic                             result_strobe,
	output smgh_pkg::result_t                result
);
	import smgh_pkg::*;
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int IW = $clog2(MAX_CLASSES);
	localparam int SW = 16 + $clog2(MAX_CLASSES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ERD  = 3'd1;
	localparam logic [2:0] ST_ET   = 3'd2;
	localparam logic [2:0] ST_EE   = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_PRD  = 3'd5;
	localparam logic [2:0] ST_PP   = 3'd6;
	localparam logic [2:0] ST_PH   = 3'd7;

	logic [2:0] state_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] n_q;
	logic signed [15:0] max_q;
	logic [4:0] label_q;
	logic [SW-1:0] sum_q;
	logic [SW:0] rem_q;
	logic [16:0] recip_q;
	logic [5:0] div_cnt_q;
	logic [16:0] t_s1;
	logic zero_s1;
	logic [3:0] lo_s1;
	logic [15:0] p_q;
	logic [31:0] hess_prod;
	logic signed [15:0] grad_val;
	logic result_strobe_q;
	result_t result_q;

	logic [16:0] diff;
	logic [15:0] d;
	logic [33:0] t_prod;
	logic [33:0] e_prod;
	logic [17:0] e_full;
	logic [15:0] e_val;
	logic [SW:0] rem_sh;
	logic rem_ge;
	logic [32:0] p_prod;
	logic [16:0] p_full;
	logic [15:0] p_sat;
	logic labelled;
	logic [15:0] a_val;
	logic last_k;

	assign diff = {max_q[15], max_q} - {logit_rdata[15], logit_rdata};
	assign d = diff[15:0];
	assign t_prod = 34'(exp_int(d[11:8])) * 34'(exp_hi(d[7:4])) + 34'd32768;
	assign e_prod = 34'(t_s1) * 34'(exp_lo(lo_s1)) + 34'd32768;
	assign e_full = e_prod[33:16];
	assign e_val = zero_s1 ? 16'd0 : ((e_full > 18'd65535) ? 16'hFFFF : e_full[15:0]);

	assign rem_sh = {rem_q[SW-1:0], (div_cnt_q == 6'd0)};
	assign rem_ge = (rem_sh >= {1'b0, sum_q});

	assign p_prod = 33'(exp_rdata) * 33'(recip_q) + 33'd65536;
	assign p_full = p_prod[32:16] >> 1;
	assign p_sat = (p_full > 17'd32768) ? 16'd32768 : p_full[15:0];

	assign labelled = (32'(label_q) == 32'(k_q) + 32'd1);
	assign a_val = labelled ? (16'd32768 - p_q) : p_q;
	assign last_k = (CW'(k_q) == n_q - CW'(1));

	assign job_take = (state_q == ST_IDLE) && job_valid;
	assign active = (state_q != ST_IDLE);
	assign logit_raddr = k_q;
	assign exp_addr = k_q;
	assign exp_we = (state_q == ST_EE);
	assign exp_wdata = e_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			div_cnt_q <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_ERD;
						k_q <= '0;
					end
				end
				ST_ERD: state_q <= ST_ET;
				ST_ET: state_q <= ST_EE;
				ST_EE: begin
					if (last_k) begin
						state_q <= ST_DIV;
						div_cnt_q <= '0;
					end else begin
						k_q <= k_q + IW'(1);
						state_q <= ST_ERD;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == 6'd32) begin
						state_q <= ST_PRD;
						k_q <= '0;
					end else begin
						div_cnt_q <= div_cnt_q + 6'd1;
					end
				end
				ST_PRD: state_q <= ST_PP;
				ST_PP: state_q <= ST_PH;
				ST_PH: begin
					result_strobe_q <= 1'b1;
					if (last_k) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + IW'(1);
						state_q <= ST_PRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			max_q <= job_max;
			label_q <= job_label;
			n_q <= n_active;
			sum_q <= '0;
		end
		if (state_q == ST_ET) begin
			t_s1 <= t_prod[32:16];
			zero_s1 <= (d[15:8] >= 8'(EXP_INT_STEPS));
			lo_s1 <= d[3:0];
		end
		if (state_q == ST_EE) begin
			sum_q <= sum_q + SW'(e_val);
		end
		if (state_q == ST_DIV) begin
			if (div_cnt_q == 6'd0) begin
				rem_q <= ({1'b0, sum_q} <= (SW+1)'(1)) ? '0 : (SW+1)'(1);
				recip_q <= ({1'b0, sum_q} <= (SW+1)'(1)) ? 17'd1 : 17'd0;
			end else begin
				rem_q <= rem_ge ? (rem_sh - {1'b0, sum_q}) : rem_sh;
				recip_q <= {recip_q[15:0], rem_ge};
			end
		end
		if (state_q == ST_PP) begin
			p_q <= p_sat;
		end
		if (state_q == ST_PH) begin
			result_q.class_index <= 4'(k_q);
			result_q.gradient <= grad_val;
			result_q.hessian <= 15'((hess_prod + 32'd8192) >> 14);
			result_q.last_class <= last_k;
		end
	end

	assign hess_prod = 32'(a_val) * 32'(16'd32768 - a_val);
	assign grad_val = labelled ? ((a_val > 16'd32767) ? 16'sd32767 : $signed(a_val))
		: $signed(16'd0 - p_q);

	assign result_strobe = result_strobe_q;
	assign result = result_q;

	`SMGH_ASSERT(a_take_idle, clk, arst_n, job_take |=> (state_q == ST_ERD))
	`SMGH_ASSERT(a_strobe_src, clk, arst_n, result_strobe |-> ($past(state_q) == ST_PH))
	`SMGH_NEVER(a_div_range, clk, arst_n, (state_q == ST_DIV) && (div_cnt_q > 6'd32))
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for softmax_gradient_hessian: directed table, then random examples.
// Depends on smgh_pkg and the block's RTL; predicts every class result with its own model.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import smgh_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic result_strobe;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	softmax_gradient_hessian dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	int unsigned class_cfg;
	int unsigned fill_cnt;
	int signed peak_logit;
	int signed logit_buf[16];
	result_t grad_queue[$];
	int errors = 0;
	int idle_cycles = 0;

	typedef struct {
		logic [15:0] logit;
		logic [4:0] label;
		logic chk;
		logic [15:0] grad0;
		logic [14:0] hess0;
	} row_t;

	function automatic int unsigned exp_q16(int unsigned d);
		int unsigned ip;
		longint unsigned t, e;
		ip = d >> 8;
		if (ip >= EXP_INT_STEPS)
			return 0;
		t = (longint'(exp_int(ip[3:0])) * exp_hi(d[7:4]) + 32768) >> 16;
		e = (t * exp_lo(d[3:0]) + 32768) >> 16;
		if (e > 65535)
			e = 65535;
		return int'(e);
	endfunction

	function automatic int unsigned classes_active();
		if (class_cfg < 2)
			return 2;
		if (class_cfg > 16)
			return 16;
		return class_cfg;
	endfunction

	task automatic predict_gradients(input logic [15:0] raw, input logic [4:0] label);
		int unsigned n, sum, a;
		int unsigned ex[16];
		longint unsigned recip, p, h;
		int signed g;
		result_t r;
		n = classes_active();
		if (fill_cnt >= n) begin
			fill_cnt = 0;
			peak_logit = -32768;
		end
		logit_buf[fill_cnt] = $signed(raw);
		if ($signed(raw) > peak_logit)
			peak_logit = $signed(raw);
		fill_cnt++;
		if (fill_cnt < n)
			return;
		sum = 0;
		for (int k = 0; k < n; k++) begin
			ex[k] = exp_q16(peak_logit - logit_buf[k]);
			sum += ex[k];
		end
		if (sum == 0)
			sum = 1;
		recip = (64'd1 << 32) / sum;
		for (int k = 0; k < n; k++) begin
			p = (longint'(ex[k]) * recip + 65536) >> 17;
			if (p > 32768)
				p = 32768;
			if (label == k + 1) begin
				a = 32768 - int'(p);
				g = (a > 32767) ? 32767 : a;
			end else begin
				a = int'(p);
				g = -a;
			end
			h = (longint'(a) * (32768 - a) + 8192) >> 14;
			r.class_index = 4'(k);
			r.gradient = 16'(g);
			r.hessian = h[14:0];
			r.last_class = (k + 1 == n);
			grad_queue.push_back(r);
		end
		fill_cnt = 0;
		peak_logit = -32768;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (grad_queue.size() == 0)
				report_mismatch("unexpected result, class", result.class_index, -1);
			else begin
				result_t w;
				w = grad_queue.pop_front();
				if (result.class_index !== w.class_index)
					report_mismatch("class_index", result.class_index, w.class_index);
				if (result.gradient !== w.gradient)
					report_mismatch("gradient", result.gradient, w.gradient);
				if (result.hessian !== w.hessian)
					report_mismatch("hessian", result.hessian, w.hessian);
				if (result.last_class !== w.last_class)
					report_mismatch("last_class", result.last_class, w.last_class);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("softmax_gradient_hessian verification failed");
			$finish;
		end
	end

	task automatic write_num_classes(input int unsigned v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_NUM_CLASSES;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		class_cfg = v & 31;
		fill_cnt = 0;
		peak_logit = -32768;
	endtask

	task automatic wait_idle();
		while (grad_queue.size() != 0)
			@(posedge clk);
		repeat (150)
			@(posedge clk);
	endtask

	int burst_left = 0;

	task automatic send_logit(input logic [15:0] raw, input logic [4:0] label);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		start <= 1'b1;
		item.logit <= raw;
		item.class_label <= label;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_gradients(raw, label);
	endtask

	row_t rows[$];

	initial begin
		int unsigned n, lbl;
		logic [15:0] base;
		class_cfg = 2;
		fill_cnt = 0;
		peak_logit = -32768;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two classes after reset: equal logits give half probability each.
		rows.push_back('{16'h0000, 5'd0, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'h0000, 5'd1, 1'b1, 16'h4000, 15'h4000});
		rows.push_back('{16'h7FFF, 5'd0, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'h8000, 5'd1, 1'b1, 16'h0000, 15'h0000});
		rows.push_back('{16'h8000, 5'd0, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'h7FFF, 5'd1, 1'b1, 16'h7FFF, 15'h0000});
		rows.push_back('{16'h8000, 5'd0, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'h7FFF, 5'd2, 1'b1, 16'h0000, 15'h0000});
		rows.push_back('{16'h0100, 5'd0, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'h0000, 5'd31, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'hFFFF, 5'd0, 1'b0, 16'h0, 15'h0});
		rows.push_back('{16'h0B00, 5'd2, 1'b0, 16'h0, 15'h0});
		foreach (rows[i]) begin
			send_logit(rows[i].logit, rows[i].label);
			if (rows[i].chk) begin
				result_t w;
				w = grad_queue[0];
				if (w.gradient !== rows[i].grad0)
					report_mismatch("table gradient", w.gradient, rows[i].grad0);
				if (w.hessian !== rows[i].hess0)
					report_mismatch("table hessian", w.hessian, rows[i].hess0);
			end
		end
		start <= 1'b0;
		wait_idle();

		// Out-of-range settings, a partial example aborted by a write, then the maximum.
		write_num_classes(0);
		send_logit(16'h1234, 5'd0);
		send_logit(16'h8765, 5'd2);
		start <= 1'b0;
		wait_idle();
		write_num_classes(31);
		send_logit(16'h0042, 5'd0);
		start <= 1'b0;
		wait_idle();
		write_num_classes(16);
		for (int k = 0; k < 16; k++)
			send_logit(16'(k * 256), (k == 15) ? 5'd16 : 5'd0);
		start <= 1'b0;
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			n = (ph == 5) ? 16 : $urandom_range(2, 8);
			write_num_classes(n);
			for (int ex = 0; ex < 30 / n + 1; ex++) begin
				base = $urandom;
				lbl = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, n);
				for (int k = 0; k < n; k++) begin
					logic [15:0] v;
					case ($urandom_range(0, 3))
						0: v = $urandom;
						1: v = base + 16'($urandom_range(0, 4095)) - 16'd2048;
						default: v = base + 16'($urandom_range(0, 511)) - 16'd256;
					endcase
					send_logit(v, (k == n - 1) ? 5'(lbl) : 5'($urandom));
				end
			end
			start <= 1'b0;
			wait_idle();
		end

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0 && grad_queue.size() == 0)
			$display("softmax_gradient_hessian verification clean");
		else
			$display("softmax_gradient_hessian verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/smgh_pkg.sv
hdl/smgh_ram.sv
hdl/smgh_front.sv
hdl/smgh_back.sv
hdl/softmax_gradient_hessian.sv
dv/tb_top.sv
